### src/u2e_pkg.sv
// Shared types, codes and a helper function for the UTF-8 to UCS-2 decoder.
package u2e_pkg;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_CONT = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_SKIP = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_UNIT  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UTF8     = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_ESCAPE   = 2'd3;

   localparam logic CSR_ESCAPES_ON = 1'b0;
   localparam logic CSR_OUT_MAX    = 1'b1;

   localparam logic [15:0] OUT_MAX_RESET = 16'd70;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [15:0] UNIT_LF     = 16'h000A;
   localparam logic [15:0] UNIT_CR     = 16'h000D;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] acc;
      logic [2:0]  remaining;
      logic [15:0] units;
   } dec_state_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] code_unit;
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [15:0] unit_count;
      logic        last;
   } dec_result_type;

   typedef struct packed {
      logic        escapes_on;
      logic [15:0] out_max;
   } csr_type;

   // Returns {valid, digit value} for one ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

### src/u2e_csr.sv
// Configuration registers of the decoder.
module u2e_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   output u2e_pkg::csr_type  csr
);
   import u2e_pkg::*;

   logic        escapes_on_ff;
   logic        escapes_on_in;
   logic [15:0] out_max_ff;
   logic [15:0] out_max_in;

   always_comb begin
      escapes_on_in = escapes_on_ff;
      out_max_in    = out_max_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ESCAPES_ON: escapes_on_in = csr_wdata[0];
            CSR_OUT_MAX:    out_max_in    = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escapes_on_ff <= 1'b0;
         out_max_ff    <= OUT_MAX_RESET;
      end else begin
         escapes_on_ff <= escapes_on_in;
         out_max_ff    <= out_max_in;
      end
   end

   assign csr.escapes_on = escapes_on_ff;
   assign csr.out_max    = out_max_ff;

endmodule

### src/u2e_decode.sv
// Combinational decode step: next decoder state and result for one byte.
module u2e_decode (
   input  u2e_pkg::dec_state_type  cur,
   input  u2e_pkg::csr_type        csr,
   input  logic [7:0]              data_byte,
   output u2e_pkg::dec_state_type  nxt,
   output u2e_pkg::dec_result_type res
);
   import u2e_pkg::*;

   logic        is_nul;
   logic        full;
   logic [4:0]  hex;
   logic [15:0] acc_cont;
   logic [15:0] acc_hex;
   logic [2:0]  rem_dec;

   assign is_nul   = (data_byte == CH_NUL);
   assign full     = (cur.units >= csr.out_max);
   assign hex      = hex_digit(data_byte);
   assign acc_cont = {cur.acc[9:0], data_byte[5:0]};
   assign acc_hex  = {cur.acc[11:0], hex[3:0]};
   assign rem_dec  = cur.remaining - 3'd1;

   always_comb begin
      logic        do_deliver;
      logic [15:0] unit;
      logic        do_fail;
      logic [1:0]  fail_code;
      logic        fail_end;

      do_deliver = 1'b0;
      unit       = 16'd0;
      do_fail    = 1'b0;
      fail_code  = ERR_NONE;
      fail_end   = 1'b0;
      nxt        = cur;
      res        = '0;

      case (cur.phase)
         PH_SKIP: begin
            if (is_nul) begin
               nxt.phase = PH_IDLE;
               nxt.units = 16'd0;
            end
         end
         PH_CONT: begin
            if (data_byte < 8'h80 || data_byte > 8'hBF) begin
               do_fail   = 1'b1;
               fail_code = ERR_UTF8;
               fail_end  = is_nul;
            end else begin
               nxt.acc       = acc_cont;
               nxt.remaining = rem_dec;
               if (rem_dec == 3'd0) begin
                  do_deliver = 1'b1;
                  unit       = acc_cont;
               end
            end
         end
         PH_ESC: begin
            if (data_byte == CH_QUOTE || data_byte == CH_BACKSLASH) begin
               do_deliver = 1'b1;
               unit       = {8'd0, data_byte};
            end else if (data_byte == CH_N) begin
               do_deliver = 1'b1;
               unit       = UNIT_LF;
            end else if (data_byte == CH_R) begin
               do_deliver = 1'b1;
               unit       = UNIT_CR;
            end else if (data_byte == CH_U) begin
               nxt.phase     = PH_HEX;
               nxt.acc       = 16'd0;
               nxt.remaining = 3'd4;
            end else begin
               do_fail   = 1'b1;
               fail_code = ERR_ESCAPE;
               fail_end  = is_nul;
            end
         end
         PH_HEX: begin
            if (!hex[4]) begin
               do_fail   = 1'b1;
               fail_code = ERR_ESCAPE;
               fail_end  = is_nul;
            end else begin
               nxt.acc       = acc_hex;
               nxt.remaining = rem_dec;
               if (rem_dec == 3'd0) begin
                  do_deliver = 1'b1;
                  unit       = acc_hex;
               end
            end
         end
         default: begin
            // Idle, and any unused phase code, starts a character or escape or ends the string.
            nxt.phase = PH_IDLE;
            if (is_nul) begin
               res.valid      = 1'b1;
               res.kind       = KIND_DONE;
               res.unit_count = cur.units;
               res.last       = 1'b1;
               nxt.units      = 16'd0;
               nxt.acc        = 16'd0;
               nxt.remaining  = 3'd0;
            end else if (data_byte == CH_BACKSLASH && csr.escapes_on) begin
               nxt.phase = PH_ESC;
            end else if (data_byte < 8'h80) begin
               do_deliver = 1'b1;
               unit       = {8'd0, data_byte};
            end else if (data_byte < 8'hC0 || data_byte > 8'hEF) begin
               do_fail   = 1'b1;
               fail_code = ERR_UTF8;
            end else begin
               nxt.acc       = {11'd0, data_byte[4:0]};
               nxt.remaining = (data_byte >= 8'hE0) ? 3'd2 : 3'd1;
               nxt.phase     = PH_CONT;
            end
         end
      endcase

      if (do_deliver && full) begin
         do_fail   = 1'b1;
         fail_code = ERR_OVERFLOW;
         fail_end  = 1'b0;
      end

      if (do_fail) begin
         res.valid      = 1'b1;
         res.code_unit  = 16'd0;
         res.kind       = KIND_ERROR;
         res.error_code = fail_code;
         res.unit_count = cur.units;
         res.last       = 1'b1;
         nxt.units      = 16'd0;
         nxt.acc        = 16'd0;
         nxt.remaining  = 3'd0;
         nxt.phase      = fail_end ? PH_IDLE : PH_SKIP;
      end else if (do_deliver) begin
         res.valid      = 1'b1;
         res.code_unit  = unit;
         res.kind       = KIND_UNIT;
         res.error_code = ERR_NONE;
         res.unit_count = cur.units + 16'd1;
         res.last       = 1'b0;
         nxt.units      = cur.units + 16'd1;
         nxt.acc        = 16'd0;
         nxt.remaining  = 3'd0;
         nxt.phase      = PH_IDLE;
      end
   end

endmodule

### src/utf8_to_ucs2_with_escapes_core.sv
// Top level of the UTF-8 to UCS-2 decoder with backslash escapes.
//
// The core takes one string byte per request and accepts a new byte in every
// cycle as long as the result side keeps up. A byte goes into an input
// register, is decoded by a single step of compare and shift logic against
// the decoder state, and its result, if it has one, lands in the output
// register: the result of a byte accepted at one clock edge is presented from
// the next edge on, unless an earlier result is still held there by a stall.
// Bytes in the middle of a multi-byte sequence or an escape, and bytes
// skipped after an error, give no result. A zero byte between characters
// ends the string with a done result carrying the code unit count.
// Configuration registers may be written only while no request is in flight.
module utf8_to_ucs2_with_escapes_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import u2e_pkg::*;

   csr_type        csr;
   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_result_type res;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff;
   dec_result_type rsp_ff;
   logic           advance;
   logic           step;

   u2e_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   u2e_decode u_decode (
      .cur       (state_ff),
      .csr       (csr),
      .data_byte (in_byte_ff),
      .nxt       (state_in),
      .res       (res)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.phase <= PH_IDLE;
         state_ff.acc   <= 16'd0;
         state_ff.remaining <= 3'd0;
         state_ff.units <= 16'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff && res.valid;
         end
         if (step) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (step && res.valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_unit  = rsp_ff.code_unit;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_error_code = rsp_ff.error_code;
   assign rsp_unit_count = rsp_ff.unit_count;
   assign rsp_last       = rsp_ff.last;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the UTF-8 to UCS-2 decoder with backslash escapes.
`timescale 1ns / 100ps

module testbench;
   import u2e_pkg::*;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [15:0] unit_count;
      logic        last;
   } decoded_type;

   typedef enum logic [1:0] {
      ROW_CHECK = 2'd0,
      ROW_TYPED = 2'd1,
      ROW_QUIET = 2'd2,
      ROW_CSR   = 2'd3
   } row_op_type;

   typedef struct packed {
      row_op_type  op;
      logic        csr_sel;
      logic [15:0] csr_value;
      logic [7:0]  data;
      decoded_type want;
   } row_type;

   localparam decoded_type NOTHING = '0;
   localparam logic [7:0] CONT_LO = 8'h80;
   localparam logic [7:0] CONT_HI = 8'hBF;
   localparam logic [7:0] LEAD_LO = 8'hC0;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD_HI = 8'hEF;
   localparam int NUM_ROWS = 33;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_GAP = 20;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_unit;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_unit_count;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_ESCAPES_ON;
   logic [15:0] csr_wdata = 16'd0;

   // Decoder state and register copies kept by the testbench.
   phase_type   dec_phase = PH_IDLE;
   logic [15:0] dec_acc = '0;
   logic [2:0]  dec_left = '0;
   logic [15:0] dec_units = '0;
   logic        cfg_escape = 1'b0;
   logic [15:0] cfg_out_max = OUT_MAX_RESET;

   decoded_type expected_q [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   logic        pin_on = 1'b0;
   logic        pin_has = 1'b0;
   decoded_type pin_res = '0;

   row_type directed_rows [NUM_ROWS] = '{
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h00, '{16'h0, KIND_DONE, ERR_NONE, 16'd0, 1'b1}},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h7F, '{16'h7F, KIND_UNIT, ERR_NONE, 16'd1, 1'b0}},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h5C, '{16'h5C, KIND_UNIT, ERR_NONE, 16'd2, 1'b0}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'hC2, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h80, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'hEF, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'hBF, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'hBF, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h80, '{16'h0, KIND_ERROR, ERR_UTF8, 16'd0, 1'b1}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h41, NOTHING},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'hE0, NOTHING},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h00, '{16'h0, KIND_ERROR, ERR_UTF8, 16'd0, 1'b1}},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'hFF, '{16'h0, KIND_ERROR, ERR_UTF8, 16'd0, 1'b1}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING},
      '{ROW_CSR, CSR_ESCAPES_ON, 16'd1, 8'h00, NOTHING},
      '{ROW_CSR, CSR_OUT_MAX, 16'd1, 8'h00, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h5C, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h75, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h61, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h46, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h30, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h39, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h5C, NOTHING},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h6E, '{16'h0, KIND_ERROR, ERR_OVERFLOW, 16'd1, 1'b1}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING},
      '{ROW_CHECK, CSR_ESCAPES_ON, 16'd0, 8'h5C, NOTHING},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h7A, '{16'h0, KIND_ERROR, ERR_ESCAPE, 16'd0, 1'b1}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING},
      '{ROW_CSR, CSR_OUT_MAX, 16'd0, 8'h00, NOTHING},
      '{ROW_TYPED, CSR_ESCAPES_ON, 16'd0, 8'h41, '{16'h0, KIND_ERROR, ERR_OVERFLOW, 16'd0, 1'b1}},
      '{ROW_QUIET, CSR_ESCAPES_ON, 16'd0, 8'h00, NOTHING}
   };

   utf8_to_ucs2_with_escapes_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_unit_count (rsp_unit_count),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic decoded_type fail_result(input logic [1:0] code, input bit at_end);
      decoded_type r;
      r = '{16'h0000, KIND_ERROR, code, dec_units, 1'b1};
      dec_units = '0;
      dec_acc = '0;
      dec_left = '0;
      dec_phase = at_end ? PH_IDLE : PH_SKIP;
      return r;
   endfunction

   function automatic decoded_type unit_result(input logic [15:0] u);
      if (dec_units >= cfg_out_max) return fail_result(ERR_OVERFLOW, 1'b0);
      dec_units = dec_units + 16'd1;
      dec_phase = PH_IDLE;
      dec_acc = '0;
      dec_left = '0;
      return '{u, KIND_UNIT, ERR_NONE, dec_units, 1'b0};
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output decoded_type r);
      logic [7:0] nib;
      r = '0;
      case (dec_phase)
         PH_SKIP: begin
            if (b == CH_NUL) begin
               dec_phase = PH_IDLE;
               dec_units = '0;
            end
            return 1'b0;
         end
         PH_CONT: begin
            if (b < CONT_LO || b > CONT_HI) begin
               r = fail_result(ERR_UTF8, b == CH_NUL);
               return 1'b1;
            end
            dec_acc = {dec_acc[9:0], b[5:0]};
            dec_left = dec_left - 3'd1;
            if (dec_left != 3'd0) return 1'b0;
            r = unit_result(dec_acc);
            return 1'b1;
         end
         PH_ESC: begin
            case (b)
               CH_QUOTE, CH_BACKSLASH: r = unit_result({8'h00, b});
               CH_N: r = unit_result(UNIT_LF);
               CH_R: r = unit_result(UNIT_CR);
               CH_U: begin
                  dec_phase = PH_HEX;
                  dec_acc = '0;
                  dec_left = 3'd4;
                  return 1'b0;
               end
               default: r = fail_result(ERR_ESCAPE, b == CH_NUL);
            endcase
            return 1'b1;
         end
         PH_HEX: begin
            if (b >= "0" && b <= "9") nib = b - "0";
            else if (b >= "a" && b <= "f") nib = b - "a" + 8'd10;
            else if (b >= "A" && b <= "F") nib = b - "A" + 8'd10;
            else begin
               r = fail_result(ERR_ESCAPE, b == CH_NUL);
               return 1'b1;
            end
            dec_acc = {dec_acc[11:0], nib[3:0]};
            dec_left = dec_left - 3'd1;
            if (dec_left != 3'd0) return 1'b0;
            r = unit_result(dec_acc);
            return 1'b1;
         end
         default: ;
      endcase
      dec_phase = PH_IDLE;
      if (b == CH_NUL) begin
         r = '{16'h0000, KIND_DONE, ERR_NONE, dec_units, 1'b1};
         dec_units = '0;
         dec_acc = '0;
         dec_left = '0;
         return 1'b1;
      end
      if (b == CH_BACKSLASH && cfg_escape) begin
         dec_phase = PH_ESC;
         return 1'b0;
      end
      if (b < CONT_LO) begin
         r = unit_result({8'h00, b});
         return 1'b1;
      end
      if (b < LEAD_LO || b > LEAD_HI) begin
         r = fail_result(ERR_UTF8, 1'b0);
         return 1'b1;
      end
      dec_acc = {11'd0, b[4:0]};
      dec_left = (b >= LEAD3_LO) ? 3'd2 : 3'd1;
      dec_phase = PH_CONT;
      return 1'b0;
   endfunction

   task automatic report(input string what, input decoded_type want, input decoded_type got);
      if (fail_count < 10) begin
         $display("%s: expected unit %h kind %0d err %0d count %0d last %0d", what,
                  want.code_unit, want.kind, want.error_code, want.unit_count, want.last);
         $display("   got unit %h kind %0d err %0d count %0d last %0d",
                  got.code_unit, got.kind, got.error_code, got.unit_count, got.last);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      decoded_type predicted;
      bit          has;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_code_unit, rsp_kind, rsp_error_code, rsp_unit_count, rsp_last};
            if (expected_q.size() == 0) begin
               report("Unexpected response", NOTHING, got);
            end else begin
               want = expected_q.pop_front();
               if (got.code_unit !== want.code_unit || got.kind !== want.kind ||
                   got.error_code !== want.error_code ||
                   got.unit_count !== want.unit_count || got.last !== want.last) begin
                  report("Response mismatch", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            has = decode_byte(req_data_byte, predicted);
            if (pin_on) begin
               has = pin_has;
               predicted = pin_res;
            end
            if (has) expected_q.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL utf8_to_ucs2_with_escapes_core");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == CSR_ESCAPES_ON) cfg_escape = value[0];
      else cfg_out_max = value;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) == 0) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   task automatic send_escape();
      send_byte(CH_BACKSLASH);
      case ($urandom_range(0, 4))
         0: send_byte(CH_QUOTE);
         1: send_byte(CH_BACKSLASH);
         2: send_byte(CH_N);
         3: send_byte(CH_R);
         default: begin
            send_byte(CH_U);
            repeat (4) send_byte(pick_hex());
         end
      endcase
   endtask

   task automatic send_char();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         2: begin
            send_byte(8'($urandom_range(LEAD_LO, LEAD3_LO - 1)));
            send_byte(8'($urandom_range(CONT_LO, CONT_HI)));
         end
         3: begin
            send_byte(8'($urandom_range(LEAD3_LO, LEAD_HI)));
            repeat (2) send_byte(8'($urandom_range(CONT_LO, CONT_HI)));
         end
         4, 5: begin
            if (cfg_escape) send_escape();
            else send_byte(8'($urandom_range(1, 127)));
         end
         default: begin
            c = 8'($urandom_range(1, 127));
            if (c == CH_BACKSLASH && cfg_escape) send_byte(CH_BACKSLASH);
            send_byte(c);
         end
      endcase
   endtask

   task automatic send_defect();
      case ($urandom_range(0, 6))
         1: send_byte(8'($urandom_range(CONT_LO, CONT_HI)));
         2: send_byte(8'($urandom_range(LEAD_HI + 1, 255)));
         3: begin
            send_byte(8'($urandom_range(LEAD_LO, LEAD_HI)));
            if ($urandom_range(0, 3) == 0) send_byte(CH_NUL);
            else send_byte(8'($urandom_range(0, 255)));
         end
         4: begin
            send_byte(CH_BACKSLASH);
            send_byte(8'($urandom_range(0, 255)));
         end
         5: begin
            send_byte(CH_BACKSLASH);
            send_byte(CH_U);
            repeat ($urandom_range(0, 3)) send_byte(pick_hex());
            send_byte(8'($urandom_range(0, 255)));
         end
         6: begin
            send_byte(CH_BACKSLASH);
            if ($urandom_range(0, 1) == 1) begin
               send_byte(CH_U);
               repeat ($urandom_range(0, 3)) send_byte(pick_hex());
            end
            send_byte(CH_NUL);
         end
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   // Mostly well-formed strings; about one in five carries a defect and trailing noise.
   task automatic send_string();
      int n_chars;
      bit broken;
      broken = ($urandom_range(0, 99) < 20);
      n_chars = $urandom_range(0, 10);
      repeat (n_chars) send_char();
      if (broken) begin
         send_defect();
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)));
      end
      send_byte(CH_NUL);
   endtask

   task automatic run_phase(input logic esc, input logic [15:0] limit, input int idle_pct,
                            input int stall_pct, input bit hold, input int budget);
      int target;
      wait_drained();
      write_reg(CSR_ESCAPES_ON, {15'd0, esc});
      write_reg(CSR_OUT_MAX, limit);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      if (hold) hold_toggle <= ~hold_toggle;
      target = bytes_sent + budget;
      while (bytes_sent < target) send_string();
   endtask

   initial begin
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < NUM_ROWS; i++) begin
         if (directed_rows[i].op == ROW_CSR) begin
            wait_drained();
            write_reg(directed_rows[i].csr_sel, directed_rows[i].csr_value);
         end else begin
            pin_on <= (directed_rows[i].op != ROW_CHECK);
            pin_has <= (directed_rows[i].op == ROW_TYPED);
            pin_res <= directed_rows[i].want;
            send_byte(directed_rows[i].data);
         end
      end
      pin_on <= 1'b0;

      run_phase(1'b1, 16'hFFFF, 0, 0, 1'b0, 250);
      run_phase(1'b0, 16'd70, 62, 0, 1'b0, 250);
      run_phase(1'b1, 16'd8, 0, 62, 1'b1, 250);
      run_phase(1'b1, 16'd0, 30, 30, 1'b0, 60);
      run_phase(1'b1, 16'd3, 0, 0, 1'b0, 250);
      run_phase(1'b0, 16'hFFFF, 30, 30, 1'b0, 250);
      run_phase(1'b1, 16'd20, 62, 0, 1'b0, 250);
      run_phase(1'b1, 16'd12, 0, 62, 1'b1, 250);

      wait_drained();
      if (fail_count == 0) begin
         $display("PASS utf8_to_ucs2_with_escapes_core");
      end else begin
         $display("FAIL utf8_to_ucs2_with_escapes_core");
      end
      $finish;
   end

endmodule
